FILE: hdl/e2q_pkg.sv
// Shared types, widths and the arctangent table of the Euler-to-quaternion unit.
package e2q_pkg;

	localparam int ANGLE_BITS_DEF     = 16;
	localparam int QUAT_FRAC_BITS_DEF = 14;
	localparam int TRIG_STAGES_DEF    = 16;

	localparam int ANGLE_W     = 16;
	localparam int QUAT_W      = 16;
	localparam int PHASE_W     = 32;
	localparam int CXY_W       = 32;
	localparam int CZ_W        = 34;
	localparam int CORDIC_ONE  = 28;
	localparam int TRIG_SH     = 12;
	localparam int TRIG_W      = 18;
	localparam int PAIR_W      = 36;
	localparam int TRIP_W      = 54;
	localparam int SUM_W       = 55;
	localparam int COMP_SH     = 24;
	localparam int COMP_W      = 28;
	localparam int NORM_W      = 56;
	localparam int SQRT_STEPS  = 28;
	localparam int ROOT_W      = 28;
	localparam int ATAN_N      = 32;
	localparam int QUEUE_DEPTH = 4;
	localparam int LANES       = 4;

	typedef logic signed [PHASE_W-1:0] phase_t;

	typedef struct packed {
		phase_t roll;
		phase_t pitch;
		phase_t yaw;
	} e2q_req_t;

	typedef struct packed {
		logic     push;
		e2q_req_t req;
	} e2q_push_t;

	typedef struct packed {
		logic     avail;
		e2q_req_t req;
	} e2q_head_t;

	// atan(2^-i) in units of 2^-32 turn
	function automatic logic [PHASE_W-1:0] atan_turn(input int i);
		case (i)
			0:  return 32'd536870912;
			1:  return 32'd316933406;
			2:  return 32'd167458907;
			3:  return 32'd85004756;
			4:  return 32'd42667331;
			5:  return 32'd21354465;
			6:  return 32'd10679838;
			7:  return 32'd5340245;
			8:  return 32'd2670163;
			9:  return 32'd1335087;
			10: return 32'd667544;
			11: return 32'd333772;
			12: return 32'd166886;
			13: return 32'd83443;
			14: return 32'd41722;
			15: return 32'd20861;
			16: return 32'd10430;
			17: return 32'd5215;
			18: return 32'd2608;
			19: return 32'd1304;
			20: return 32'd652;
			21: return 32'd326;
			22: return 32'd163;
			23: return 32'd81;
			24: return 32'd41;
			25: return 32'd20;
			26: return 32'd10;
			27: return 32'd5;
			28: return 32'd3;
			29: return 32'd1;
			30: return 32'd1;
			default: return 32'd0;
		endcase
	endfunction

	function automatic int cordic_steps(input int stages);
		return (stages > ATAN_N) ? ATAN_N : stages;
	endfunction

	// add or subtract two triple products, round Q48 to Q24
	function automatic logic signed [COMP_W-1:0] comp_round(
		input logic signed [TRIP_W-1:0] a,
		input logic signed [TRIP_W-1:0] b,
		input logic                     sub
	);
		logic signed [SUM_W-1:0] sum;
		sum = sub ? (SUM_W'(a) - SUM_W'(b)) : (SUM_W'(a) + SUM_W'(b));
		sum = sum + (SUM_W'(1) <<< (COMP_SH - 1));
		return COMP_W'(sum >>> COMP_SH);
	endfunction

endpackage

FILE: hdl/e2q_angle_if.sv
// Request channel carrying roll, pitch and yaw angles.
interface e2q_angle_if import e2q_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [ANGLE_W-1:0] roll_angle;
	logic [ANGLE_W-1:0] pitch_angle;
	logic [ANGLE_W-1:0] yaw_angle;

	modport source(output valid, output roll_angle, output pitch_angle, output yaw_angle,
		input ready);
	modport sink(input valid, input roll_angle, input pitch_angle, input yaw_angle,
		output ready);
endinterface

FILE: hdl/e2q_quat_if.sv
// Result channel carrying the unit quaternion.
interface e2q_quat_if import e2q_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [QUAT_W-1:0] quat_w;
	logic signed [QUAT_W-1:0] quat_x;
	logic signed [QUAT_W-1:0] quat_y;
	logic signed [QUAT_W-1:0] quat_z;

	modport source(output valid, output quat_w, output quat_x, output quat_y, output quat_z,
		input ready);
	modport sink(input valid, input quat_w, input quat_x, input quat_y, input quat_z,
		output ready);
endinterface

FILE: hdl/e2q_front.sv
// Front end: accepts angle requests and turns each angle into a CORDIC start phase.
module e2q_front import e2q_pkg::*; #(
	parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
	e2q_angle_if.sink angles,
	input  logic      full,
	output e2q_push_t push
);

	// mask, scale to a 32-bit turn, halve, rotate back by a quarter turn
	function automatic phase_t half_phase(input logic [ANGLE_W-1:0] a);
		logic [63:0]        m;
		logic [PHASE_W-1:0] ph;
		m  = 64'(a) & ((64'd1 << ANGLE_BITS) - 64'd1);
		ph = PHASE_W'(m << (PHASE_W - ANGLE_BITS));
		return $signed({1'b0, ph[PHASE_W-1:1]}) - (PHASE_W'(1) <<< (PHASE_W - 2));
	endfunction

	assign angles.ready   = !full;
	assign push.push      = angles.valid && !full;
	assign push.req.roll  = half_phase(angles.roll_angle);
	assign push.req.pitch = half_phase(angles.pitch_angle);
	assign push.req.yaw   = half_phase(angles.yaw_angle);

endmodule

FILE: hdl/e2q_queue.sv
// Short request queue between the front end and the arithmetic back end.
module e2q_queue import e2q_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  e2q_push_t push,
	output logic      full,
	input  logic      pop,
	output e2q_head_t head
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	e2q_req_t         mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full       = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign head.avail = (cnt_q != '0);
	assign head.req   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push.push)
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (push.push && !pop)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (!push.push && pop)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push.push)
			mem_q[wr_ptr_q] <= push.req;
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(QUEUE_DEPTH)) else $error("queue count above depth");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push.push |-> !full) else $error("push into full queue");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != '0) else $error("pop from empty queue");

endmodule

FILE: hdl/e2q_cordic.sv
// Pipelined CORDIC rotator giving the half-angle sine and cosine in Q16.
module e2q_cordic import e2q_pkg::*; #(
	parameter int STEPS = TRIG_STAGES_DEF
) (
	input  logic                     clk,
	input  logic                     en,
	input  phase_t                   phase,
	output logic signed [TRIG_W-1:0] sin_half,
	output logic signed [TRIG_W-1:0] cos_half
);

	localparam logic signed [CXY_W-1:0] X_START = CXY_W'(1) <<< CORDIC_ONE;
	localparam logic signed [CXY_W:0]   RND     = (CXY_W + 1)'(1) <<< (TRIG_SH - 1);

	logic signed [CXY_W-1:0] x_q [STEPS+1];
	logic signed [CXY_W-1:0] y_q [STEPS+1];
	logic signed [CZ_W-1:0]  z_q [STEPS+1];

	always_ff @(posedge clk) begin
		if (en) begin
			x_q[0] <= X_START;
			y_q[0] <= '0;
			z_q[0] <= CZ_W'(phase);
			for (int i = 0; i < STEPS; i++) begin
				if (!z_q[i][CZ_W-1]) begin
					x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] - $signed(CZ_W'(atan_turn(i)));
				end else begin
					x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] + $signed(CZ_W'(atan_turn(i)));
				end
			end
			// sine is x, cosine is -y after the quarter-turn offset
			sin_half <= TRIG_W'(((CXY_W + 1)'(x_q[STEPS]) + RND) >>> TRIG_SH);
			cos_half <= TRIG_W'((RND - (CXY_W + 1)'(y_q[STEPS])) >>> TRIG_SH);
		end
	end

endmodule

FILE: hdl/e2q_back.sv
// Back end: trig, quaternion products, norm square root and normalizing division.
module e2q_back import e2q_pkg::*; #(
	parameter int QUAT_FRAC_BITS = QUAT_FRAC_BITS_DEF,
	parameter int TRIG_STAGES    = TRIG_STAGES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  e2q_head_t   head,
	output logic        pop,
	e2q_quat_if.source  quat
);

	localparam int F    = QUAT_FRAC_BITS;
	localparam int NS   = cordic_steps(TRIG_STAGES);
	localparam int NW   = ROOT_W + F + 1;
	localparam int QW   = F + 1;
	localparam int RW   = NORM_W + 1;
	localparam int DV0  = NS + 7 + SQRT_STEPS;
	localparam int LAT  = DV0 + F + 3;
	localparam logic [QW-1:0] LIM = QW'(1) << F;

	logic            en;
	logic [LAT-1:0]  vld_q;

	logic signed [TRIG_W-1:0] sr, cr, sp, cp, sy, cy;

	logic signed [PAIR_W-1:0] cc_s1, ss_s1, cs_s1, sc_s1;
	logic signed [TRIG_W-1:0] sr_s1, cr_s1;
	logic signed [TRIP_W-1:0] t_s2 [8];
	logic signed [COMP_W-1:0] comp_s3 [LANES];
	logic signed [COMP_W-1:0] comp_s4 [LANES];
	logic        [NORM_W-1:0] sqr_s4 [LANES];

	logic        [NORM_W-1:0] sq_v [SQRT_STEPS+1];
	logic        [RW-1:0]     sq_r [SQRT_STEPS+1];
	logic signed [COMP_W-1:0] sq_c [SQRT_STEPS+1][LANES];

	logic [NW-1:0]     dv_rem  [F+2][LANES];
	logic [QW-1:0]     dv_q    [F+2][LANES];
	logic              dv_neg  [F+2][LANES];
	logic [ROOT_W-1:0] dv_s    [F+2];
	logic              dv_zero [F+2];

	logic [QUAT_W-1:0] out_q [LANES];

	assign en  = !vld_q[LAT-1] || quat.ready;
	assign pop = en && head.avail;

	e2q_cordic #(.STEPS(NS)) u_roll (
		.clk(clk), .en(en), .phase(head.req.roll), .sin_half(sr), .cos_half(cr));
	e2q_cordic #(.STEPS(NS)) u_pitch (
		.clk(clk), .en(en), .phase(head.req.pitch), .sin_half(sp), .cos_half(cp));
	e2q_cordic #(.STEPS(NS)) u_yaw (
		.clk(clk), .en(en), .phase(head.req.yaw), .sin_half(sy), .cos_half(cy));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], head.avail};
		end
	end

	always_ff @(posedge clk) begin
		logic [RW-1:0]     bitv;
		logic [RW-1:0]     trial;
		logic [NW-1:0]     sh;
		logic [COMP_W-1:0] mag;
		logic [QW-1:0]     qc;
		logic [63:0]       r64;
		if (en) begin
			cc_s1 <= PAIR_W'(cy) * PAIR_W'(cp);
			ss_s1 <= PAIR_W'(sy) * PAIR_W'(sp);
			cs_s1 <= PAIR_W'(cy) * PAIR_W'(sp);
			sc_s1 <= PAIR_W'(sy) * PAIR_W'(cp);
			sr_s1 <= sr;
			cr_s1 <= cr;

			t_s2[0] <= TRIP_W'(cc_s1) * TRIP_W'(cr_s1);
			t_s2[1] <= TRIP_W'(ss_s1) * TRIP_W'(sr_s1);
			t_s2[2] <= TRIP_W'(cc_s1) * TRIP_W'(sr_s1);
			t_s2[3] <= TRIP_W'(ss_s1) * TRIP_W'(cr_s1);
			t_s2[4] <= TRIP_W'(cs_s1) * TRIP_W'(cr_s1);
			t_s2[5] <= TRIP_W'(sc_s1) * TRIP_W'(sr_s1);
			t_s2[6] <= TRIP_W'(sc_s1) * TRIP_W'(cr_s1);
			t_s2[7] <= TRIP_W'(cs_s1) * TRIP_W'(sr_s1);

			comp_s3[0] <= comp_round(t_s2[0], t_s2[1], 1'b0);
			comp_s3[1] <= comp_round(t_s2[2], t_s2[3], 1'b1);
			comp_s3[2] <= comp_round(t_s2[4], t_s2[5], 1'b0);
			comp_s3[3] <= comp_round(t_s2[6], t_s2[7], 1'b1);

			for (int k = 0; k < LANES; k++) begin
				comp_s4[k] <= comp_s3[k];
				sqr_s4[k]  <= NORM_W'(NORM_W'(comp_s3[k]) * NORM_W'(comp_s3[k]));
			end

			sq_v[0] <= (sqr_s4[0] + sqr_s4[1]) + (sqr_s4[2] + sqr_s4[3]);
			sq_r[0] <= '0;
			for (int k = 0; k < LANES; k++)
				sq_c[0][k] <= comp_s4[k];

			// one root bit per stage
			for (int j = 0; j < SQRT_STEPS; j++) begin
				bitv  = RW'(1) << (2 * (SQRT_STEPS - 1 - j));
				trial = sq_r[j] + bitv;
				if ({1'b0, sq_v[j]} >= trial) begin
					sq_v[j+1] <= NORM_W'({1'b0, sq_v[j]} - trial);
					sq_r[j+1] <= (sq_r[j] >> 1) + bitv;
				end else begin
					sq_v[j+1] <= sq_v[j];
					sq_r[j+1] <= sq_r[j] >> 1;
				end
				for (int k = 0; k < LANES; k++)
					sq_c[j+1][k] <= sq_c[j][k];
			end

			dv_s[0]    <= ROOT_W'(sq_r[SQRT_STEPS]);
			dv_zero[0] <= (sq_r[SQRT_STEPS] == '0);
			for (int k = 0; k < LANES; k++) begin
				mag = sq_c[SQRT_STEPS][k][COMP_W-1] ? COMP_W'(-sq_c[SQRT_STEPS][k])
					: COMP_W'(sq_c[SQRT_STEPS][k]);
				dv_neg[0][k] <= sq_c[SQRT_STEPS][k][COMP_W-1];
				dv_q[0][k]   <= '0;
				dv_rem[0][k] <= (NW'(mag) << F) + NW'(sq_r[SQRT_STEPS][ROOT_W-1:1]);
			end

			// one quotient bit per stage, most significant first
			for (int j = 0; j <= F; j++) begin
				dv_s[j+1]    <= dv_s[j];
				dv_zero[j+1] <= dv_zero[j];
				sh = NW'(dv_s[j]) << (F - j);
				for (int k = 0; k < LANES; k++) begin
					dv_neg[j+1][k] <= dv_neg[j][k];
					if (dv_rem[j][k] >= sh) begin
						dv_rem[j+1][k] <= dv_rem[j][k] - sh;
						dv_q[j+1][k]   <= dv_q[j][k] | (QW'(1) << (F - j));
					end else begin
						dv_rem[j+1][k] <= dv_rem[j][k];
						dv_q[j+1][k]   <= dv_q[j][k];
					end
				end
			end

			for (int k = 0; k < LANES; k++) begin
				qc  = (dv_q[F+1][k] > LIM) ? LIM : dv_q[F+1][k];
				r64 = dv_neg[F+1][k] ? (64'd0 - 64'(qc)) : 64'(qc);
				if (dv_zero[F+1])
					out_q[k] <= (k == 0) ? QUAT_W'(64'(LIM)) : '0;
				else
					out_q[k] <= r64[QUAT_W-1:0];
			end
		end
	end

	assign quat.valid  = vld_q[LAT-1];
	assign quat.quat_w = out_q[0];
	assign quat.quat_x = out_q[1];
	assign quat.quat_y = out_q[2];
	assign quat.quat_z = out_q[3];

	a_norm_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[DV0] |-> !dv_zero[0]) else $error("zero quaternion norm");
	a_div_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[DV0] |-> (dv_rem[0][0] < (NW'(dv_s[0]) << QW))
			&& (dv_rem[0][1] < (NW'(dv_s[0]) << QW))
			&& (dv_rem[0][2] < (NW'(dv_s[0]) << QW))
			&& (dv_rem[0][3] < (NW'(dv_s[0]) << QW)))
		else $error("component larger than norm");
	a_quot_limit: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[LAT-2] |-> (dv_q[F+1][0] <= LIM) && (dv_q[F+1][1] <= LIM)
			&& (dv_q[F+1][2] <= LIM) && (dv_q[F+1][3] <= LIM))
		else $error("normalized component above one");

endmodule

FILE: hdl/euler_to_quaternion_unit.sv
// Euler angles (ZYX) to unit quaternion, top level.
// Usage:
//   angles: request channel with roll_angle, pitch_angle, yaw_angle, each a
//     binary angle where 2^ANGLE_BITS is a full turn. A request is taken when
//     valid and ready are high at a rising clk edge.
//   quat: result channel with quat_w, quat_x, quat_y, quat_z in signed Q1.14
//     (QUAT_FRAC_BITS fraction bits), one result per request, in order.
// Throughput: one request per cycle while quat.ready holds high. Every stage of
//   the back end is a register, so the CORDIC stages, the 28-step square root
//   and the QUAT_FRAC_BITS+1 step divider all overlap across requests.
// Path: with an empty queue, a taken request is written into the queue, then
//   passes the CORDIC stages, the product, rounding and norm-sum registers,
//   the square root and the divider before quat.valid rises with its result.
// Stall: when quat.ready is low with quat.valid high the back end holds; the
//   four-entry queue keeps taking requests until it fills, then angles.ready drops.
// Reset: arst_n low clears the queue and all valid bits; no result is pending
//   after reset and no clearing pass is needed.
module euler_to_quaternion_unit import e2q_pkg::*; #(
	parameter int ANGLE_BITS     = ANGLE_BITS_DEF,
	parameter int QUAT_FRAC_BITS = QUAT_FRAC_BITS_DEF,
	parameter int TRIG_STAGES    = TRIG_STAGES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	e2q_angle_if.sink  angles,
	e2q_quat_if.source quat
);

	e2q_push_t push;
	e2q_head_t head;
	logic      full;
	logic      pop;

	e2q_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
		.angles(angles),
		.full  (full),
		.push  (push)
	);

	e2q_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.pop   (pop),
		.head  (head)
	);

	e2q_back #(
		.QUAT_FRAC_BITS(QUAT_FRAC_BITS),
		.TRIG_STAGES   (TRIG_STAGES)
	) u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.head  (head),
		.pop   (pop),
		.quat  (quat)
	);

endmodule

FILE: test/tb_euler_to_quaternion_unit.sv
// Testbench for the Euler-to-quaternion unit: directed and random angle requests checked against a predictor.
module tb_euler_to_quaternion_unit;
	import e2q_pkg::*;

	localparam int LATENCY = 69;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic signed [QUAT_W-1:0] w;
		logic signed [QUAT_W-1:0] x;
		logic signed [QUAT_W-1:0] y;
		logic signed [QUAT_W-1:0] z;
	} quat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int cycle_count = 0;
	int errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	quat_t expected_quats[$];

	e2q_angle_if angles();
	e2q_quat_if quat();

	euler_to_quaternion_unit dut(.clk(clk), .arst_n(arst_n), .angles(angles), .quat(quat));

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		angles.valid = 1'b0;
		angles.roll_angle = '0;
		angles.pitch_angle = '0;
		angles.yaw_angle = '0;
		quat.ready = 1'b0;
	end

	function automatic longint shr_floor(longint v, int k);
		return v >>> k;
	endfunction

	// half-angle sine and cosine in Q16, CORDIC gain kept
	function automatic void half_trig(logic [ANGLE_W-1:0] a, output longint sn, output longint cs);
		longint px, py, pz, dx, dy;
		logic [31:0] ph;
		ph = {a, 16'h0};
		pz = longint'(ph >> 1) - (longint'(1) << 30);
		px = longint'(1) << 28;
		py = 0;
		for (int i = 0; i < 16; i++) begin
			dx = shr_floor(py, i);
			dy = shr_floor(px, i);
			if (pz >= 0) begin
				px -= dx; py += dy; pz -= longint'(atan_turn(i));
			end else begin
				px += dx; py -= dy; pz += longint'(atan_turn(i));
			end
		end
		sn = shr_floor(px + 2048, 12);
		cs = shr_floor(-py + 2048, 12);
	endfunction

	function automatic longint int_sqrt(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return longint'(res);
	endfunction

	function automatic logic signed [QUAT_W-1:0] scale_comp(longint c, longint s);
		longint mag, q;
		mag = (c < 0) ? -c : c;
		q = ((mag << 14) + (s >> 1)) / s;
		if (q > 16384) q = 16384;
		return QUAT_W'((c < 0) ? -q : q);
	endfunction

	function automatic quat_t euler_to_quat(logic [15:0] r, logic [15:0] p, logic [15:0] yw);
		longint sr, cr, sp, cp, sy, cy, s;
		longint c[4];
		longint unsigned n2;
		quat_t q;
		half_trig(r, sr, cr);
		half_trig(p, sp, cp);
		half_trig(yw, sy, cy);
		c[0] = cy * cp * cr + sy * sp * sr;
		c[1] = cy * cp * sr - sy * sp * cr;
		c[2] = cy * sp * cr + sy * cp * sr;
		c[3] = sy * cp * cr - cy * sp * sr;
		n2 = 0;
		for (int k = 0; k < 4; k++) begin
			c[k] = shr_floor(c[k] + (longint'(1) << 23), 24);
			n2 += longint'(c[k] * c[k]);
		end
		s = int_sqrt(n2);
		if (s == 0) begin
			q = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0};
		end else begin
			q.w = scale_comp(c[0], s);
			q.x = scale_comp(c[1], s);
			q.y = scale_comp(c[2], s);
			q.z = scale_comp(c[3], s);
		end
		return q;
	endfunction

	task automatic send_angles(logic [15:0] r, logic [15:0] p, logic [15:0] yw);
		while ($urandom_range(99) < send_idle_pct) begin
			angles.valid <= 1'b0;
			@(posedge clk);
		end
		angles.valid <= 1'b1;
		angles.roll_angle <= r;
		angles.pitch_angle <= p;
		angles.yaw_angle <= yw;
		do @(posedge clk); while (!angles.ready);
		expected_quats.push_back(euler_to_quat(r, p, yw));
	endtask

	task automatic go_quiet();
		angles.valid <= 1'b0;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		quat.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		quat_t got, want;
		cycle_count <= cycle_count + 1;
		if (arst_n && quat.valid && quat.ready) begin
			got = '{quat.quat_w, quat.quat_x, quat.quat_y, quat.quat_z};
			if (expected_quats.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
			end else begin
				want = expected_quats.pop_front();
				if (got.w !== want.w) begin
					$display("%0t: w expected %0d actual %0d", $time, want.w, got.w);
					errors++;
				end
				if (got.x !== want.x) begin
					$display("%0t: x expected %0d actual %0d", $time, want.x, got.x);
					errors++;
				end
				if (got.y !== want.y) begin
					$display("%0t: y expected %0d actual %0d", $time, want.y, got.y);
					errors++;
				end
				if (got.z !== want.z) begin
					$display("%0t: z expected %0d actual %0d", $time, want.z, got.z);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_euler_to_quaternion_unit failed");
			$finish;
		end
	end

	task automatic test_directed();
		logic [15:0] corners[8] = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000,
			16'hC000, 16'h7FFF, 16'h0001, 16'h5555};
		for (int i = 0; i < 8; i++) send_angles(corners[i], corners[i], corners[i]);
		for (int i = 0; i < 8; i++) send_angles(corners[i], corners[7 - i], corners[(i + 3) % 8]);
		for (int b = 0; b < 16; b++) send_angles(16'h1 << b, ~(16'h1 << b), 16'h1 << (15 - b));
		go_quiet();
	endtask

	task automatic test_random(int n, int idle, int stall);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		for (int i = 0; i < n; i++)
			send_angles(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
				16'($urandom_range(16'hFFFF)));
		go_quiet();
	endtask

	// hold off the sender until the pipeline has drained
	task automatic test_drain_pause();
		test_random(40, 0, 30);
		while (expected_quats.size() != 0) @(posedge clk);
		test_random(40, 0, 0);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(300, 0, 0);
		test_random(300, 60, 0);
		test_random(300, 0, 60);
		test_random(300, 21, 21);
		test_drain_pause();
		recv_stall_pct = 0;
		while (expected_quats.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0 && expected_quats.size() == 0)
			$display("tb_euler_to_quaternion_unit passed");
		else
			$display("tb_euler_to_quaternion_unit failed");
		$finish;
	end
endmodule
